// ===== sv/assert_macros.svh =====
// Assertion macros used by the evaluator RTL.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== sv/hsc_pkg.sv =====
// Types and constants of the Hermite spline curve evaluator.
// No dependencies.
`default_nettype none
package hsc_pkg;

    localparam int KEY_W   = 48;
    localparam int IDX_W   = 5;
    localparam int KC_W    = 6;
    localparam int DIG_W   = 17;
    localparam int NDIG    = 3;
    localparam int MA_W    = 50;
    localparam int MB_W    = 51;
    localparam int ACC_W   = 104;
    localparam int SDATA_W = 248;
    localparam int MDATA_W = 48;
    localparam int MUSER_W = 3;

    localparam int OFF_IDX  = 0;
    localparam int OFF_X    = 5;
    localparam int OFF_Y    = 53;
    localparam int OFF_SIN  = 101;
    localparam int OFF_SOUT = 149;
    localparam int OFF_Q    = 197;

    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_EVAL  = 1'b1;

    localparam logic [1:0] REGION_BELOW  = 2'd0;
    localparam logic [1:0] REGION_INSIDE = 2'd1;
    localparam logic [1:0] REGION_ABOVE  = 2'd2;

    typedef struct packed {
        logic signed [KEY_W-1:0] slope_out;
        logic signed [KEY_W-1:0] slope_in;
        logic signed [KEY_W-1:0] y;
        logic signed [KEY_W-1:0] x;
    } t_key;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD0,
        ST_CHK0,
        ST_RDN,
        ST_CHKN,
        ST_RDI,
        ST_CHKI,
        ST_CMP,
        ST_DIV,
        ST_MUL,
        ST_BAS,
        ST_FIN
    } t_state;

    typedef enum logic [3:0] {
        OP_EXT,
        OP_T2,
        OP_T3,
        OP_H1,
        OP_H2,
        OP_S0,
        OP_S1,
        OP_S2,
        OP_S3
    } t_op;

endpackage
`default_nettype wire

// ===== sv/hermite_spline_curve_evaluator.sv =====
// Cubic Hermite keyframe curve evaluator; depends on hsc_pkg and assert_macros.svh.
// Sequence: a write beat is stored when taken; a query at or below the first key or at or above
//   the last key extrapolates; an interior one scans keys, returns y on a key, else interpolates.
// Throughput: one item at a time, next beat in the cycle after the result loads; a full output
//   register holds the result; divide 1 bit/cycle, 50x18 multiply 1 digit.
// Reset: synchronous active low; clears control, key_count to 1; key table not cleared.
`default_nettype none
`include "assert_macros.svh"
module hermite_spline_curve_evaluator #(
    parameter int MAX_KEYS  = 32,
    parameter int FRAC_BITS = 24
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_s_tvalid,
    output logic                         o_s_tready,
    // key_index, key_x, key_y, key_slope_in, key_slope_out, query_x, zero pad
    input  logic [hsc_pkg::SDATA_W-1:0]  i_s_tdata,
    // kind
    input  logic [0:0]                   i_s_tuser,
    output logic                         o_m_tvalid,
    input  logic                         i_m_tready,
    // y_value
    output logic [hsc_pkg::MDATA_W-1:0]  o_m_tdata,
    // region, saturated
    output logic [hsc_pkg::MUSER_W-1:0]  o_m_tuser,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [hsc_pkg::KC_W-1:0]     i_cfg_data
);
    import hsc_pkg::*;

    localparam int IW    = $clog2(MAX_KEYS);
    localparam int AXW   = (IW > IDX_W) ? IW : IDX_W;
    localparam int TW    = FRAC_BITS;
    localparam int HW    = FRAC_BITS + 3;
    localparam int CNT_W = $clog2(FRAC_BITS + 1);

    t_key r_mem [MAX_KEYS];
    t_key r_rd;
    t_key r_lo;
    t_key r_hi;

    t_state r_state;
    t_state n_state;
    t_op    r_op;
    logic [1:0]       r_dig;
    logic [CNT_W-1:0] r_cnt;
    logic [IW-1:0]    r_idx;
    logic [KC_W-1:0]  r_kc;

    logic signed [KEY_W-1:0] r_x;
    logic signed [KEY_W:0]   r_dx;
    logic signed [KEY_W-1:0] r_es;
    logic [KEY_W-1:0]        r_rem;
    logic [KEY_W-1:0]        r_iv;
    logic [TW-1:0]           r_t;
    logic [TW-1:0]           r_t2;
    logic [TW-1:0]           r_t3;
    logic signed [HW-1:0]    r_h0;
    logic signed [HW-1:0]    r_h1;
    logic signed [HW-1:0]    r_h2;
    logic signed [HW-1:0]    r_h3;
    logic signed [MA_W-1:0]  r_h1s;
    logic signed [MA_W-1:0]  r_h2s;
    logic signed [ACC_W-1:0] r_acc;
    logic [1:0]              r_region;

    logic                    r_out_valid;
    logic [KEY_W-1:0]        r_out_y;
    logic [1:0]              r_out_region;
    logic                    r_out_sat;

    logic             w_s_acc;
    logic [IDX_W-1:0] w_in_idx;
    logic [AXW-1:0]   w_kidx_ext;
    logic [IW-1:0]    w_wr_addr;
    logic             w_wr_ok;
    t_key             w_in_key;
    logic [IW-1:0]    w_rd_addr;
    logic [IW:0]      w_n;
    logic [IW:0]      w_nm1;
    logic [IW-1:0]    w_last;
    logic             w_fin_load;

    logic                    w_le0;
    logic                    w_gen;
    logic                    w_more;
    logic signed [KEY_W:0]   w_dx;
    logic signed [KEY_W:0]   w_num;
    logic signed [KEY_W:0]   w_den;
    logic [KEY_W:0]          w_rem2;
    logic [KEY_W:0]          w_sub;
    logic                    w_qbit;
    logic                    w_last_dig;

    logic signed [MA_W-1:0]    w_ma;
    logic signed [MB_W-1:0]    w_mb;
    logic [DIG_W-1:0]          w_dig_u;
    logic signed [DIG_W:0]     w_dig;
    logic signed [MA_W+DIG_W:0] w_prod;
    logic signed [ACC_W-1:0]   w_prod_ext;
    logic signed [ACC_W-1:0]   w_part;
    logic signed [ACC_W-1:0]   w_acc_nx;

    logic signed [HW-1:0]    w_t2s;
    logic signed [HW-1:0]    w_t3s;
    logic signed [HW-1:0]    w_one;

    logic signed [ACC_W-1:0] w_half;
    logic signed [ACC_W-1:0] w_rnd;
    logic signed [ACC_W-1:0] w_sh;
    logic                    w_fit;
    logic [KEY_W-1:0]        w_y;

    // input beat fields
    assign w_s_acc        = i_s_tvalid & o_s_tready;
    assign w_in_idx       = i_s_tdata[OFF_IDX +: IDX_W];
    assign w_in_key.x         = i_s_tdata[OFF_X +: KEY_W];
    assign w_in_key.y         = i_s_tdata[OFF_Y +: KEY_W];
    assign w_in_key.slope_in  = i_s_tdata[OFF_SIN +: KEY_W];
    assign w_in_key.slope_out = i_s_tdata[OFF_SOUT +: KEY_W];
    assign w_kidx_ext     = AXW'(w_in_idx);
    assign w_wr_addr      = w_kidx_ext[IW-1:0];
    assign w_wr_ok        = int'(w_in_idx) < MAX_KEYS;

    assign o_cfg_ready = 1'b1;

    always_comb begin
        priority if (r_kc == '0) begin
            w_n = (IW+1)'(1);
        end else if (int'(r_kc) > MAX_KEYS) begin
            w_n = (IW+1)'(MAX_KEYS);
        end else begin
            w_n = (IW+1)'(r_kc);
        end
    end
    assign w_nm1  = w_n - (IW+1)'(1);
    assign w_last = w_nm1[IW-1:0];

    // key table
    always_ff @(posedge i_clk) begin
        if (w_s_acc && i_s_tuser[0] == KIND_WRITE && w_wr_ok) begin
            r_mem[w_wr_addr] <= w_in_key;
        end
        r_rd <= r_mem[w_rd_addr];
    end

    // compares and differences on the read key
    assign w_le0  = r_x <= r_rd.x;
    assign w_gen  = r_x >= r_rd.x;
    assign w_more = (r_idx != w_last) && (r_rd.x < r_x);
    assign w_dx   = (KEY_W+1)'(r_x) - (KEY_W+1)'(r_rd.x);
    assign w_num  = (KEY_W+1)'(r_x) - (KEY_W+1)'(r_lo.x);
    assign w_den  = (KEY_W+1)'(r_rd.x) - (KEY_W+1)'(r_lo.x);

    // restoring divide step
    assign w_rem2 = {r_rem, 1'b0};
    assign w_qbit = w_rem2 >= {1'b0, r_iv};
    assign w_sub  = w_rem2 - {1'b0, r_iv};

    // shared multiply-accumulate, one 17-bit digit of B per cycle
    always_comb begin
        unique case (r_op)
            OP_T2: begin
                w_ma = MA_W'(r_t);
                w_mb = MB_W'(r_t);
            end
            OP_T3: begin
                w_ma = MA_W'(r_t2);
                w_mb = MB_W'(r_t);
            end
            OP_H1: begin
                w_ma = MA_W'(r_iv);
                w_mb = MB_W'(r_h1);
            end
            OP_H2: begin
                w_ma = MA_W'(r_iv);
                w_mb = MB_W'(r_h2);
            end
            OP_S0: begin
                w_ma = MA_W'(r_lo.y);
                w_mb = MB_W'(r_h0);
            end
            OP_S1: begin
                w_ma = MA_W'(r_lo.slope_out);
                w_mb = MB_W'(r_h1s);
            end
            OP_S2: begin
                w_ma = MA_W'(r_hi.slope_in);
                w_mb = MB_W'(r_h2s);
            end
            OP_S3: begin
                w_ma = MA_W'(r_hi.y);
                w_mb = MB_W'(r_h3);
            end
            default: begin
                w_ma = MA_W'(r_dx);
                w_mb = MB_W'(r_es);
            end
        endcase
    end

    assign w_last_dig = r_dig == 2'(NDIG - 1);

    always_comb begin
        unique case (r_dig)
            2'd0:    w_dig_u = w_mb[0 +: DIG_W];
            2'd1:    w_dig_u = w_mb[DIG_W +: DIG_W];
            default: w_dig_u = w_mb[2*DIG_W +: DIG_W];
        endcase
    end
    assign w_dig      = w_last_dig ? {w_dig_u[DIG_W-1], w_dig_u} : {1'b0, w_dig_u};
    assign w_prod     = w_ma * w_dig;
    assign w_prod_ext = ACC_W'(w_prod);

    always_comb begin
        unique case (r_dig)
            2'd0:    w_part = w_prod_ext;
            2'd1:    w_part = w_prod_ext <<< DIG_W;
            default: w_part = w_prod_ext <<< (2 * DIG_W);
        endcase
    end
    assign w_acc_nx = r_acc + w_part;

    // basis inputs
    assign w_t2s = $signed(HW'(r_t2));
    assign w_t3s = $signed(HW'(r_t3));
    assign w_one = $signed(HW'(1) << FRAC_BITS);

    // round, shift, saturate
    assign w_half = $signed(ACC_W'(1) << (FRAC_BITS - 1));
    assign w_rnd  = r_acc + w_half;
    assign w_sh   = w_rnd >>> FRAC_BITS;
    assign w_fit  = (&w_sh[ACC_W-1:KEY_W-1]) | ~(|w_sh[ACC_W-1:KEY_W-1]);
    always_comb begin
        priority if (w_fit) begin
            w_y = w_sh[KEY_W-1:0];
        end else if (w_sh[ACC_W-1]) begin
            w_y = {1'b1, {(KEY_W-1){1'b0}}};
        end else begin
            w_y = {1'b0, {(KEY_W-1){1'b1}}};
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_s_acc && i_s_tuser[0] == KIND_EVAL) n_state = ST_RD0;
            end
            ST_RD0:  n_state = ST_CHK0;
            ST_CHK0: n_state = w_le0 ? ST_MUL : ST_RDN;
            ST_RDN:  n_state = ST_CHKN;
            ST_CHKN: n_state = w_gen ? ST_MUL : ST_RDI;
            ST_RDI:  n_state = ST_CHKI;
            ST_CHKI: n_state = w_more ? ST_RDI : ST_CMP;
            ST_CMP:  n_state = (r_rem >= r_iv) ? ST_FIN : ST_DIV;
            ST_DIV: begin
                if (r_cnt == CNT_W'(FRAC_BITS - 1)) n_state = ST_MUL;
            end
            ST_MUL: begin
                if (w_last_dig) begin
                    priority if (r_op == OP_EXT || r_op == OP_S3) begin
                        n_state = ST_FIN;
                    end else if (r_op == OP_T3) begin
                        n_state = ST_BAS;
                    end else begin
                        n_state = ST_MUL;
                    end
                end
            end
            ST_BAS:  n_state = ST_MUL;
            ST_FIN: begin
                if (w_fin_load) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        o_s_tready = 1'b0;
        w_rd_addr  = r_idx;
        w_fin_load = 1'b0;
        unique case (r_state)
            ST_IDLE: o_s_tready = 1'b1;
            ST_RD0:  w_rd_addr  = '0;
            ST_RDN:  w_rd_addr  = w_last;
            ST_FIN:  w_fin_load = ~r_out_valid | i_m_tready;
            default: ;
        endcase
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_op    <= OP_EXT;
            r_dig   <= '0;
            r_cnt   <= '0;
            r_idx   <= '0;
            r_kc    <= KC_W'(1);
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) r_kc <= i_cfg_data;
            unique case (r_state)
                ST_CHK0: begin
                    r_op  <= OP_EXT;
                    r_dig <= '0;
                end
                ST_CHKN: begin
                    r_op  <= OP_EXT;
                    r_dig <= '0;
                    r_idx <= IW'(1);
                end
                ST_CHKI: begin
                    if (w_more) r_idx <= r_idx + IW'(1);
                end
                ST_CMP: r_cnt <= '0;
                ST_DIV: begin
                    r_cnt <= r_cnt + CNT_W'(1);
                    r_op  <= OP_T2;
                    r_dig <= '0;
                end
                ST_MUL: begin
                    if (w_last_dig) begin
                        r_dig <= '0;
                        unique case (r_op)
                            OP_T2:   r_op <= OP_T3;
                            OP_T3:   r_op <= OP_H1;
                            OP_H1:   r_op <= OP_H2;
                            OP_H2:   r_op <= OP_S0;
                            OP_S0:   r_op <= OP_S1;
                            OP_S1:   r_op <= OP_S2;
                            OP_S2:   r_op <= OP_S3;
                            default: r_op <= r_op;
                        endcase
                    end else begin
                        r_dig <= r_dig + 2'd1;
                    end
                end
                default: ;
            endcase
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                r_x <= i_s_tdata[OFF_Q +: KEY_W];
            end
            ST_CHK0: begin
                r_lo     <= r_rd;
                r_region <= REGION_BELOW;
                r_dx     <= w_dx;
                r_es     <= r_rd.slope_in;
                r_acc    <= ACC_W'(r_rd.y) <<< FRAC_BITS;
            end
            ST_CHKN: begin
                r_region <= REGION_ABOVE;
                r_dx     <= w_dx;
                r_es     <= r_rd.slope_out;
                r_acc    <= ACC_W'(r_rd.y) <<< FRAC_BITS;
            end
            ST_CHKI: begin
                if (w_more) begin
                    r_lo <= r_rd;
                end else begin
                    r_hi     <= r_rd;
                    r_region <= REGION_INSIDE;
                    r_rem    <= w_num[KEY_W-1:0];
                    r_iv     <= w_den[KEY_W-1:0];
                end
            end
            ST_CMP: begin
                r_acc <= ACC_W'(r_hi.y) <<< FRAC_BITS;
            end
            ST_DIV: begin
                r_rem <= w_qbit ? w_sub[KEY_W-1:0] : w_rem2[KEY_W-1:0];
                r_t   <= {r_t[TW-2:0], w_qbit};
                r_acc <= '0;
            end
            ST_MUL: begin
                if (w_last_dig) begin
                    unique case (r_op)
                        OP_T2: begin
                            r_t2  <= w_acc_nx[FRAC_BITS +: TW];
                            r_acc <= '0;
                        end
                        OP_T3: begin
                            r_t3  <= w_acc_nx[FRAC_BITS +: TW];
                            r_acc <= '0;
                        end
                        OP_H1: begin
                            r_h1s <= w_acc_nx[FRAC_BITS +: MA_W];
                            r_acc <= '0;
                        end
                        OP_H2: begin
                            r_h2s <= w_acc_nx[FRAC_BITS +: MA_W];
                            r_acc <= '0;
                        end
                        default: r_acc <= w_acc_nx;
                    endcase
                end else begin
                    r_acc <= w_acc_nx;
                end
            end
            ST_BAS: begin
                r_h0 <= (w_t3s <<< 1) - (w_t2s + (w_t2s <<< 1)) + w_one;
                r_h1 <= w_t3s - (w_t2s <<< 1) + $signed(HW'(r_t));
                r_h2 <= w_t3s - w_t2s;
                r_h3 <= (w_t2s + (w_t2s <<< 1)) - (w_t3s <<< 1);
            end
            default: ;
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fin_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fin_load) begin
            r_out_y      <= w_y;
            r_out_region <= r_region;
            r_out_sat    <= ~w_fit;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_y;
    assign o_m_tuser  = {r_out_sat, r_out_region};

    `ASSERT_IMPLIES(a_div_rem, i_clk, i_rst_n, r_state == ST_DIV, r_rem < r_iv)
    `ASSERT_IMPLIES(a_scan_idx, i_clk, i_rst_n, r_state == ST_CHKI, r_idx <= w_last && r_idx != '0)
    `ASSERT_NEXT(a_fin_out, i_clk, i_rst_n, w_fin_load, o_m_tvalid && r_state == ST_IDLE)
    `ASSERT_IMPLIES(a_region, i_clk, i_rst_n, o_m_tvalid, o_m_tuser[1:0] <= REGION_ABOVE)

endmodule
`default_nettype wire
